/* design/pta_pkg.sv */
// ----------------------------------------------------------------------------
// pta_pkg: shared types and constants of the pixel to ascii text converter
// Payload structs, the control word of the sequencer and the text constants.
// ----------------------------------------------------------------------------
package pta_pkg;

  // luminance weights in Q16, they sum to one
  localparam logic [16:0] LUMA_RED_Q16   = 17'd13933;
  localparam logic [16:0] LUMA_GREEN_Q16 = 17'd46871;
  localparam logic [16:0] LUMA_BLUE_Q16  = 17'd4732;
  localparam int          MAX_GRADIENT   = 16;

  // white in Q16: 255 * 65536
  localparam logic [25:0] FULL_SCALE = 26'd16711680;

  // text bytes
  localparam logic [7:0] CH_ESC    = 8'h1B;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_M      = 8'h6D;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_TWO    = 8'h32;
  localparam logic [7:0] CH_THREE  = 8'h33;
  localparam logic [7:0] CH_EIGHT  = 8'h38;

  // configuration register indexes
  localparam logic [2:0] CFG_SCALE_X     = 3'd0;
  localparam logic [2:0] CFG_SCALE_Y     = 3'd1;
  localparam logic [2:0] CFG_COLOUR_MODE = 3'd2;
  localparam logic [2:0] CFG_GRAD_LOW    = 3'd3;
  localparam logic [2:0] CFG_GRAD_HIGH   = 3'd4;
  localparam logic [2:0] CFG_GRAD_LEN    = 3'd5;

  typedef logic [4:0] step_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       row_end;
    logic       frame_end;
  } in_pix_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
  } out_txt_t;

  // where the emitted byte comes from
  typedef enum logic [2:0] {
    SRC_LIT,
    SRC_HUND,
    SRC_TENS,
    SRC_UNIT,
    SRC_GLYPH
  } src_t;

  typedef enum logic [1:0] {
    CHAN_RED,
    CHAN_GREEN,
    CHAN_BLUE
  } chan_t;

  // when a step puts a byte out
  typedef enum logic [1:0] {
    EM_NONE,
    EM_ALWAYS,
    EM_GE100,
    EM_GE10
  } em_t;

  typedef enum logic [1:0] {
    LAST_NO,
    LAST_YES,
    LAST_NOT_ROWFIN
  } last_t;

  // jump conditions
  typedef enum logic [2:0] {
    J_NONE,
    J_ALWAYS,
    J_NO_INPUT,
    J_NOT_KEEP,
    J_NOT_COLOUR,
    J_NOT_ROWFIN
  } jmp_t;

  typedef struct packed {
    logic       take_in;
    logic       op_luma;
    logic       op_glyph;
    src_t       src;
    chan_t      chan;
    logic [7:0] lit;
    em_t        emit;
    last_t      last;
    jmp_t       jmp;
    step_t      target;
  } ctl_t;

  localparam ctl_t CTL_NOP = '{
    take_in:  1'b0,
    op_luma:  1'b0,
    op_glyph: 1'b0,
    src:      SRC_LIT,
    chan:     CHAN_RED,
    lit:      8'h00,
    emit:     EM_NONE,
    last:     LAST_NO,
    jmp:      J_NONE,
    target:   5'd0
  };

  // status seen by the sequencer
  typedef struct packed {
    logic in_accept;
    logic keep;
    logic colour;
    logic rowfin;
    logic hold;
  } stat_t;

  // binary to three bcd digits by shift and add three
  function automatic logic [11:0] to_bcd(input logic [7:0] v);
    logic [11:0] bcd;
    bcd = 12'd0;
    for (int i = 7; i >= 0; i--) begin
      if (bcd[3:0] >= 4'd5) bcd[3:0] = bcd[3:0] + 4'd3;
      if (bcd[7:4] >= 4'd5) bcd[7:4] = bcd[7:4] + 4'd3;
      bcd = {bcd[10:0], v[i]};
    end
    return bcd;
  endfunction

endpackage

/* design/pixel_to_ascii_text.sv */
// ----------------------------------------------------------------------------
// pixel_to_ascii_text: pixel stream to ascii art text bytes
// Intake: a new pixel is taken only in the idle step, after the last one's steps.
// Throughput: one byte per cycle while out_ready lets the output register take
// it; a pixel needs more steps of the microcode sequencer in colour mode.
// Reset: synchronous; phases clear, config registers return to defaults.
// Subsamples pixels, maps luminance to a glyph and adds colour escapes.
// ----------------------------------------------------------------------------
module pixel_to_ascii_text
  import pta_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_pix_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_txt_t    out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  // configuration
  logic [7:0]  scale_x_r, scale_y_r;
  logic        colour_mode_r;
  logic [63:0] grad_low_r, grad_high_r;
  logic [4:0]  grad_len_r;

  // pixel state
  logic [7:0]  col_phase_r, row_phase_r;
  in_pix_t     pix_r;
  logic        keep_r, rowfin_r;
  logic [11:0] red_bcd_r, green_bcd_r, blue_bcd_r;
  logic [25:0] luma_r;
  logic [7:0]  glyph_r;

  // output register
  logic        out_valid_r;
  out_txt_t    out_data_r;

  ctl_t        ctl;
  stat_t       stat;
  logic        in_acc, out_free, want, fire;
  logic [11:0] bcd_sel;
  logic [3:0]  digit;
  logic [7:0]  byte_sel;
  logic        last_sel;
  logic [7:0]  col_nxt, row_nxt;
  logic [7:0]  sx, sy;
  logic [8:0]  col_inc, row_inc;
  logic        row_end_eff;
  logic [25:0] luma_nxt;
  logic [3:0]  len_m1;
  logic [23:0] diff;
  logic [27:0] prod;
  logic [11:0] qsum;
  logic [3:0]  gidx;
  logic [127:0] grad_all;

  assign in_acc    = in_valid && in_ready;
  assign in_ready  = ctl.take_in;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  pta_sequencer u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctl   (ctl)
  );

  assign stat.in_accept = in_acc;
  assign stat.keep      = keep_r;
  assign stat.colour    = colour_mode_r;
  assign stat.rowfin    = rowfin_r;
  assign stat.hold      = want && !out_free;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_x_r     <= 8'd1;
      scale_y_r     <= 8'd1;
      colour_mode_r <= 1'b0;
      grad_low_r    <= 64'd0;
      grad_high_r   <= 64'd0;
      grad_len_r    <= 5'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SCALE_X:     scale_x_r     <= cfg_data[7:0];
        CFG_SCALE_Y:     scale_y_r     <= cfg_data[7:0];
        CFG_COLOUR_MODE: colour_mode_r <= cfg_data[0];
        CFG_GRAD_LOW:    grad_low_r    <= cfg_data;
        CFG_GRAD_HIGH:   grad_high_r   <= cfg_data;
        CFG_GRAD_LEN:    grad_len_r    <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // phase advance, a zero scale acts as one
  always_comb begin
    sx          = (scale_x_r == 8'd0) ? 8'd1 : scale_x_r;
    sy          = (scale_y_r == 8'd0) ? 8'd1 : scale_y_r;
    col_inc     = {1'b0, col_phase_r} + 9'd1;
    row_inc     = {1'b0, row_phase_r} + 9'd1;
    row_end_eff = in_data.row_end || in_data.frame_end;
    if (row_end_eff) begin
      col_nxt = 8'd0;
      if (in_data.frame_end || row_inc >= {1'b0, sy}) begin
        row_nxt = 8'd0;
      end else begin
        row_nxt = row_inc[7:0];
      end
    end else begin
      row_nxt = row_phase_r;
      col_nxt = (col_inc >= {1'b0, sx}) ? 8'd0 : col_inc[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_phase_r <= 8'd0;
      row_phase_r <= 8'd0;
    end else if (in_acc) begin
      col_phase_r <= col_nxt;
      row_phase_r <= row_nxt;
    end
  end

  // pixel capture and keep decision
  always_ff @(posedge clk) begin
    if (in_acc) begin
      pix_r    <= in_data;
      keep_r   <= (row_phase_r == 8'd0) && (col_phase_r == 8'd0);
      rowfin_r <= row_end_eff && (row_phase_r == 8'd0);
    end
  end

  // luminance and decimal digits
  assign luma_nxt = 26'(LUMA_RED_Q16)   * 26'(pix_r.red)
                  + 26'(LUMA_GREEN_Q16) * 26'(pix_r.green)
                  + 26'(LUMA_BLUE_Q16)  * 26'(pix_r.blue);

  always_ff @(posedge clk) begin
    if (ctl.op_luma) begin
      luma_r      <= luma_nxt;
      red_bcd_r   <= to_bcd(pix_r.red);
      green_bcd_r <= to_bcd(pix_r.green);
      blue_bcd_r  <= to_bcd(pix_r.blue);
    end
  end

  // glyph index: floor((F - S) * (len - 1) / (255 * 65536))
  always_comb begin
    if (grad_len_r == 5'd0) begin
      len_m1 = 4'd0;
    end else if (grad_len_r > 5'(MAX_GRADIENT)) begin
      len_m1 = 4'(MAX_GRADIENT - 1);
    end else begin
      len_m1 = 4'(grad_len_r - 5'd1);
    end
    diff     = (luma_r > FULL_SCALE) ? 24'd0 : 24'(FULL_SCALE - luma_r);
    prod     = 28'(diff) * 28'(len_m1);
    // divide by 255 on the upper bits: (y + y/256 + 1) / 256
    qsum     = prod[27:16] + {8'd0, prod[27:24]} + 12'd1;
    gidx     = qsum[11:8];
    grad_all = {grad_high_r, grad_low_r};
  end

  always_ff @(posedge clk) begin
    if (ctl.op_glyph) begin
      glyph_r <= grad_all[{gidx, 3'b000} +: 8];
    end
  end

  // byte select
  always_comb begin
    unique case (ctl.chan)
      CHAN_RED:   bcd_sel = red_bcd_r;
      CHAN_GREEN: bcd_sel = green_bcd_r;
      CHAN_BLUE:  bcd_sel = blue_bcd_r;
      default:    bcd_sel = blue_bcd_r;
    endcase
    unique case (ctl.src)
      SRC_HUND: digit = bcd_sel[11:8];
      SRC_TENS: digit = bcd_sel[7:4];
      default:  digit = bcd_sel[3:0];
    endcase
    unique case (ctl.src)
      SRC_LIT:   byte_sel = ctl.lit;
      SRC_GLYPH: byte_sel = glyph_r;
      default:   byte_sel = CH_ZERO + {4'd0, digit};
    endcase
    unique case (ctl.emit)
      EM_NONE:   want = 1'b0;
      EM_ALWAYS: want = 1'b1;
      EM_GE100:  want = (bcd_sel[11:8] != 4'd0);
      EM_GE10:   want = (bcd_sel[11:4] != 8'd0);
      default:   want = 1'b0;
    endcase
    unique case (ctl.last)
      LAST_YES:        last_sel = 1'b1;
      LAST_NOT_ROWFIN: last_sel = !rowfin_r;
      default:         last_sel = 1'b0;
    endcase
  end

  assign out_free = !out_valid_r || out_ready;
  assign fire     = want && out_free;

  // output register, one transfer per cycle while the receiver is ready
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r.out_byte <= byte_sel;
      out_data_r.run_last <= last_sel;
    end
  end

endmodule

/* design/pta_sequencer.sv */
// ----------------------------------------------------------------------------
// pta_sequencer: microcode store and step counter
// One control word per step; the step advances, holds on a stalled byte, or
// jumps on a condition from the datapath.
// ----------------------------------------------------------------------------
module pta_sequencer
  import pta_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  stat_t stat,
  output ctl_t  ctl
);

  localparam step_t ST_IDLE  = 5'd0;
  localparam step_t ST_LUMA  = 5'd1;
  localparam step_t ST_GIDX  = 5'd2;
  localparam step_t ST_CSEL  = 5'd3;
  localparam step_t ST_E0    = 5'd4;
  localparam step_t ST_E1    = 5'd5;
  localparam step_t ST_E2    = 5'd6;
  localparam step_t ST_E3    = 5'd7;
  localparam step_t ST_E4    = 5'd8;
  localparam step_t ST_E5    = 5'd9;
  localparam step_t ST_E6    = 5'd10;
  localparam step_t ST_RH    = 5'd11;
  localparam step_t ST_RT    = 5'd12;
  localparam step_t ST_RU    = 5'd13;
  localparam step_t ST_RS    = 5'd14;
  localparam step_t ST_GH    = 5'd15;
  localparam step_t ST_GT    = 5'd16;
  localparam step_t ST_GU    = 5'd17;
  localparam step_t ST_GS    = 5'd18;
  localparam step_t ST_BH    = 5'd19;
  localparam step_t ST_BT    = 5'd20;
  localparam step_t ST_BU    = 5'd21;
  localparam step_t ST_BM    = 5'd22;
  localparam step_t ST_GLYPH = 5'd23;
  localparam step_t ST_ROW   = 5'd24;
  localparam step_t ST_RSEL  = 5'd25;
  localparam step_t ST_X0    = 5'd26;
  localparam step_t ST_X1    = 5'd27;
  localparam step_t ST_X2    = 5'd28;
  localparam step_t ST_X3    = 5'd29;
  localparam step_t ST_NL    = 5'd30;

  step_t step_r, step_nxt;
  logic  taken;

  // step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ST_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

  // control store
  always_comb begin
    ctl = CTL_NOP;
    unique case (step_r)
      ST_IDLE: begin
        ctl.take_in = 1'b1;
        ctl.jmp     = J_NO_INPUT;
        ctl.target  = ST_IDLE;
      end
      ST_LUMA: ctl.op_luma = 1'b1;
      ST_GIDX: begin
        ctl.op_glyph = 1'b1;
        ctl.jmp      = J_NOT_KEEP;
        ctl.target   = ST_ROW;
      end
      ST_CSEL: begin
        ctl.jmp    = J_NOT_COLOUR;
        ctl.target = ST_GLYPH;
      end
      ST_E0: begin ctl.emit = EM_ALWAYS; ctl.lit = CH_ESC;    end
      ST_E1: begin ctl.emit = EM_ALWAYS; ctl.lit = CH_LBRACK; end
      ST_E2: begin ctl.emit = EM_ALWAYS; ctl.lit = CH_THREE;  end
      ST_E3: begin ctl.emit = EM_ALWAYS; ctl.lit = CH_EIGHT;  end
      ST_E4: begin ctl.emit = EM_ALWAYS; ctl.lit = CH_SEMI;   end
      ST_E5: begin ctl.emit = EM_ALWAYS; ctl.lit = CH_TWO;    end
      ST_E6: begin ctl.emit = EM_ALWAYS; ctl.lit = CH_SEMI;   end
      ST_RH: begin ctl.emit = EM_GE100;  ctl.src = SRC_HUND; ctl.chan = CHAN_RED; end
      ST_RT: begin ctl.emit = EM_GE10;   ctl.src = SRC_TENS; ctl.chan = CHAN_RED; end
      ST_RU: begin ctl.emit = EM_ALWAYS; ctl.src = SRC_UNIT; ctl.chan = CHAN_RED; end
      ST_RS: begin ctl.emit = EM_ALWAYS; ctl.lit = CH_SEMI;   end
      ST_GH: begin ctl.emit = EM_GE100;  ctl.src = SRC_HUND; ctl.chan = CHAN_GREEN; end
      ST_GT: begin ctl.emit = EM_GE10;   ctl.src = SRC_TENS; ctl.chan = CHAN_GREEN; end
      ST_GU: begin ctl.emit = EM_ALWAYS; ctl.src = SRC_UNIT; ctl.chan = CHAN_GREEN; end
      ST_GS: begin ctl.emit = EM_ALWAYS; ctl.lit = CH_SEMI;   end
      ST_BH: begin ctl.emit = EM_GE100;  ctl.src = SRC_HUND; ctl.chan = CHAN_BLUE; end
      ST_BT: begin ctl.emit = EM_GE10;   ctl.src = SRC_TENS; ctl.chan = CHAN_BLUE; end
      ST_BU: begin ctl.emit = EM_ALWAYS; ctl.src = SRC_UNIT; ctl.chan = CHAN_BLUE; end
      ST_BM: begin ctl.emit = EM_ALWAYS; ctl.lit = CH_M;      end
      ST_GLYPH: begin
        ctl.emit = EM_ALWAYS;
        ctl.src  = SRC_GLYPH;
        ctl.last = LAST_NOT_ROWFIN;
      end
      ST_ROW: begin
        ctl.jmp    = J_NOT_ROWFIN;
        ctl.target = ST_IDLE;
      end
      ST_RSEL: begin
        ctl.jmp    = J_NOT_COLOUR;
        ctl.target = ST_NL;
      end
      ST_X0: begin ctl.emit = EM_ALWAYS; ctl.lit = CH_ESC;    end
      ST_X1: begin ctl.emit = EM_ALWAYS; ctl.lit = CH_LBRACK; end
      ST_X2: begin ctl.emit = EM_ALWAYS; ctl.lit = CH_ZERO;   end
      ST_X3: begin ctl.emit = EM_ALWAYS; ctl.lit = CH_M;      end
      ST_NL: begin
        ctl.emit   = EM_ALWAYS;
        ctl.lit    = CH_NL;
        ctl.last   = LAST_YES;
        ctl.jmp    = J_ALWAYS;
        ctl.target = ST_IDLE;
      end
      default: begin
        ctl.jmp    = J_ALWAYS;
        ctl.target = ST_IDLE;
      end
    endcase
  end

  // jump condition
  always_comb begin
    unique case (ctl.jmp)
      J_NONE:       taken = 1'b0;
      J_ALWAYS:     taken = 1'b1;
      J_NO_INPUT:   taken = !stat.in_accept;
      J_NOT_KEEP:   taken = !stat.keep;
      J_NOT_COLOUR: taken = !stat.colour;
      J_NOT_ROWFIN: taken = !stat.rowfin;
      default:      taken = 1'b1;
    endcase
  end

  // next step
  always_comb begin
    if (stat.hold) begin
      step_nxt = step_r;
    end else if (taken) begin
      step_nxt = ctl.target;
    end else begin
      step_nxt = step_r + 5'd1;
    end
  end

endmodule

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb: self-checking testbench of pixel_to_ascii_text
// Feeds raster pixels through the valid/ready input and predicts every text
// byte (colour escape, glyph, row reset, newline) from its own copy of the
// scale phases and registers. Directed corner cases come first, then random
// frames under random idling on both sides and one long receiver hold-off.
// ----------------------------------------------------------------------------
import pta_pkg::*;

// predicts the text bytes of each transferred pixel and checks them in order
class text_scoreboard;
  bit [7:0]  scale_x;
  bit [7:0]  scale_y;
  bit        colour;
  bit [63:0] glyphs_low;
  bit [63:0] glyphs_high;
  bit [4:0]  glyph_count;
  bit [7:0]  col_phase;
  bit [7:0]  row_phase;
  bit [7:0]  pixel_text[$];
  out_txt_t  expected_bytes[$];
  int        mismatches;

  function new();
    scale_x     = 8'd1;
    scale_y     = 8'd1;
    colour      = 1'b0;
    glyphs_low  = '0;
    glyphs_high = '0;
    glyph_count = 5'd1;
    col_phase   = '0;
    row_phase   = '0;
    mismatches  = 0;
  endfunction

  function void set_reg(logic [2:0] idx, logic [63:0] v);
    case (idx)
      CFG_SCALE_X:     scale_x = v[7:0];
      CFG_SCALE_Y:     scale_y = v[7:0];
      CFG_COLOUR_MODE: colour = v[0];
      CFG_GRAD_LOW:    glyphs_low = v;
      CFG_GRAD_HIGH:   glyphs_high = v;
      CFG_GRAD_LEN:    glyph_count = v[4:0];
      default: ;
    endcase
  endfunction

  // append one byte to the text of the current pixel
  function void put_char(bit [7:0] c);
    pixel_text = {pixel_text, c};
  endfunction

  // a scale of zero counts as one, a phase at or past the scale wraps
  function bit [7:0] next_phase(bit [7:0] ph, bit [7:0] sc);
    int lim;
    int nxt;
    lim = (sc == 0) ? 1 : int'(sc);
    nxt = int'(ph) + 1;
    return (nxt >= lim) ? 8'd0 : nxt[7:0];
  endfunction

  // decimal without leading zeros
  function void add_decimal(bit [7:0] v);
    if (v >= 100) put_char(8'(CH_ZERO + v / 100));
    if (v >= 10) put_char(8'(CH_ZERO + (v / 10) % 10));
    put_char(8'(CH_ZERO + v % 10));
  endfunction

  function bit [7:0] glyph_for(bit [7:0] r, bit [7:0] g, bit [7:0] b);
    longint unsigned span;
    longint unsigned luma;
    longint unsigned idx;
    bit [3:0]        sel;
    span = (glyph_count == 0) ? 1 :
           (glyph_count > MAX_GRADIENT) ? MAX_GRADIENT : glyph_count;
    luma = longint'(LUMA_RED_Q16) * r + longint'(LUMA_GREEN_Q16) * g +
           longint'(LUMA_BLUE_Q16) * b;
    if (luma > FULL_SCALE) idx = 0;
    else idx = ((longint'(FULL_SCALE) - luma) * (span - 1)) / FULL_SCALE;
    sel = idx[3:0];
    return (sel < 8) ? glyphs_low[8 * sel +: 8] : glyphs_high[8 * (sel - 8) +: 8];
  endfunction

  function void note_pixel(in_pix_t p);
    bit       line_end;
    bit       row_kept;
    out_txt_t t;
    pixel_text.delete();
    line_end = p.row_end || p.frame_end;
    row_kept = (row_phase == 0);
    // kept pixel: optional truecolor escape, then the glyph
    if (row_kept && col_phase == 0) begin
      if (colour) begin
        put_char(CH_ESC);
        put_char(CH_LBRACK);
        put_char(CH_THREE);
        put_char(CH_EIGHT);
        put_char(CH_SEMI);
        put_char(CH_TWO);
        put_char(CH_SEMI);
        add_decimal(p.red);
        put_char(CH_SEMI);
        add_decimal(p.green);
        put_char(CH_SEMI);
        add_decimal(p.blue);
        put_char(CH_M);
      end
      put_char(glyph_for(p.red, p.green, p.blue));
    end
    // row end, frame end counts as one too
    if (line_end) begin
      if (row_kept) begin
        if (colour) begin
          put_char(CH_ESC);
          put_char(CH_LBRACK);
          put_char(CH_ZERO);
          put_char(CH_M);
        end
        put_char(CH_NL);
      end
      col_phase = '0;
      row_phase = p.frame_end ? 8'd0 : next_phase(row_phase, scale_y);
    end else begin
      col_phase = next_phase(col_phase, scale_x);
    end
    foreach (pixel_text[i]) begin
      t.out_byte = pixel_text[i];
      t.run_last = (i == pixel_text.size() - 1);
      expected_bytes = {expected_bytes, t};
    end
  endfunction

  function void check_byte(out_txt_t got);
    out_txt_t want;
    if (expected_bytes.size() == 0) begin
      if (mismatches < 10)
        $display("unexpected byte %02h last %0b", got.out_byte, got.run_last);
      mismatches++;
    end else begin
      want = expected_bytes.pop_front();
      if (got.out_byte !== want.out_byte || got.run_last !== want.run_last) begin
        if (mismatches < 10)
          $display("byte mismatch: expected %02h last %0b, got %02h last %0b",
                   want.out_byte, want.run_last, got.out_byte, got.run_last);
        mismatches++;
      end
    end
  endfunction
endclass

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_CYCLES = 2000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES   = 40;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_pix_t     in_data;
  logic        out_valid;
  logic        out_ready;
  out_txt_t    out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;

  text_scoreboard sb;
  bit             calm;
  bit             stall_req;
  int             pixels_sent;
  int             idle_cycles;

  pixel_to_ascii_text i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // mostly short gaps, a few long ones, none in a calm phase
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic bit [7:0] pick_level();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'($urandom_range(0, 9));
      3: return 8'($urandom_range(10, 99));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic bit [7:0] pick_scale();
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'd255;
      2, 3: return 8'd1;
      4, 5: return 8'd2;
      6: return 8'd3;
      default: return 8'($urandom_range(1, 8));
    endcase
  endfunction

  function automatic bit [63:0] pick_glyphs();
    case ($urandom_range(0, 5))
      0: return '1;
      1: return '0;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic bit [4:0] pick_length();
    case ($urandom_range(0, 7))
      0: return 5'd0;
      1: return 5'($urandom_range(17, 31));
      2: return 5'd16;
      3: return 5'd1;
      default: return 5'($urandom_range(2, 16));
    endcase
  endfunction

  // one pixel transfer; valid stays up for a back-to-back pixel
  task automatic send_pixel(bit [7:0] r, bit [7:0] g, bit [7:0] b, bit re, bit fe);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = '{red: r, green: g, blue: b, row_end: re, frame_end: fe};
    do @(posedge clk); while (!in_ready);
    sb.note_pixel(in_data);
    pixels_sent++;
    @(negedge clk);
  endtask

  // wait for every expected byte, then let a byte-less pixel finish
  task automatic drain();
    in_valid = 1'b0;
    while (sb.expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] v);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, v);
    @(negedge clk);
  endtask

  task automatic setup(bit [7:0] sx, bit [7:0] sy, bit col, bit [63:0] lo,
                       bit [63:0] hi, bit [4:0] len);
    drain();
    write_reg(CFG_SCALE_X, 64'(sx));
    write_reg(CFG_SCALE_Y, 64'(sy));
    write_reg(CFG_COLOUR_MODE, 64'(col));
    write_reg(CFG_GRAD_LOW, lo);
    write_reg(CFG_GRAD_HIGH, hi);
    write_reg(CFG_GRAD_LEN, 64'(len));
    cfg_valid = 1'b0;
  endtask

  // well-formed frame with random content, now and then broken marks
  task automatic send_frame();
    int rows;
    int width;
    bit re;
    bit fe;
    rows = $urandom_range(1, 3);
    for (int y = 0; y < rows; y++) begin
      width = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 8);
      for (int x = 0; x < width; x++) begin
        re = (x == width - 1);
        fe = re && (y == rows - 1);
        if ($urandom_range(0, 11) == 0) begin
          re = 1'($urandom_range(0, 1));
          fe = 1'($urandom_range(0, 1));
        end
        send_pixel(pick_level(), pick_level(), pick_level(), re, fe);
      end
    end
  endtask

  // result side: random ready, one long hold-off on request
  initial begin
    int stall_left;
    int idle_left;
    stall_left = 0;
    idle_left  = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_req) begin
        stall_left = HOLD_OFF_CYCLES;
        stall_req  = 1'b0;
      end
      if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else if (idle_left > 0) begin
        out_ready = 1'b0;
        idle_left--;
      end else begin
        out_ready = 1'b1;
        if ($urandom_range(0, 2) == 0) idle_left = pick_gap();
      end
    end
  end

  // check each byte transfer
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_byte(out_data);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG_CYCLES) begin
      $display("watchdog: no transfer for %0d cycles", WATCHDOG_CYCLES);
      $display("** pixel_to_ascii_text: FAILED **");
      $finish;
    end
  end

  initial begin
    int start;
    sb          = new();
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_valid   = 1'b0;
    cfg_index   = CFG_SCALE_X;
    cfg_data    = '0;
    calm        = 1'b0;
    stall_req   = 1'b0;
    pixels_sent = 0;
    idle_cycles = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // defaults after reset: plain mode, one glyph
    send_pixel(8'd0, 8'd0, 8'd0, 1'b0, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b1, 1'b0);

    // colour mode, full gradient of digits and capitals, every digit count
    setup(8'd1, 8'd1, 1'b1, 64'h3736353433323130, 64'h4645444342413938, 5'd16);
    send_pixel(8'd0, 8'd0, 8'd0, 1'b0, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b0, 1'b0);
    send_pixel(8'd255, 8'd0, 8'd0, 1'b0, 1'b0);
    send_pixel(8'd0, 8'd255, 8'd0, 1'b0, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd255, 1'b1, 1'b0);
    send_pixel(8'd5, 8'd47, 8'd200, 1'b0, 1'b0);
    // frame end without row end
    send_pixel(8'd100, 8'd10, 8'd9, 1'b0, 1'b1);
    send_pixel(8'd128, 8'd64, 8'd32, 1'b1, 1'b1);

    // zero row scale, zero length; leave the column phase at three
    setup(8'd5, 8'd0, 1'b0, 64'h3736353433323130, 64'h4645444342413938, 5'd0);
    send_pixel(8'd10, 8'd20, 8'd30, 1'b0, 1'b0);
    send_pixel(8'd1, 8'd2, 8'd3, 1'b0, 1'b0);
    send_pixel(8'd200, 8'd100, 8'd50, 1'b0, 1'b0);

    // column phase past the new scale wraps; oversized length; skipped rows
    setup(8'd2, 8'd255, 1'b1, '1, '0, 5'd31);
    send_pixel(8'd9, 8'd9, 8'd9, 1'b0, 1'b0);
    send_pixel(8'd99, 8'd99, 8'd99, 1'b0, 1'b0);
    send_pixel(8'd7, 8'd7, 8'd7, 1'b0, 1'b0);
    send_pixel(8'd250, 8'd1, 8'd60, 1'b1, 1'b0);
    send_pixel(8'd3, 8'd3, 8'd3, 1'b0, 1'b0);
    send_pixel(8'd4, 8'd4, 8'd4, 1'b1, 1'b0);
    send_pixel(8'd5, 8'd5, 8'd5, 1'b0, 1'b1);
    send_pixel(8'd77, 8'd88, 8'd99, 1'b1, 1'b1);

    // random phases, the third one with the long hold-off in colour mode
    for (int p = 0; p < 6; p++) begin
      if (p == 0)
        setup(8'd255, 8'd1, 1'b0, pick_glyphs(), pick_glyphs(), 5'd16);
      else
        setup(pick_scale(), pick_scale(), (p == 2) ? 1'b1 : 1'($urandom_range(0, 1)),
              pick_glyphs(), pick_glyphs(), pick_length());
      calm = ($urandom_range(0, 3) == 0);
      if (p == 2) stall_req = 1'b1;
      start = pixels_sent;
      while (pixels_sent - start < 17) send_frame();
    end

    drain();
    if (sb.expected_bytes.size() != 0)
      $display("%0d expected bytes never arrived", sb.expected_bytes.size());
    if (sb.mismatches == 0 && sb.expected_bytes.size() == 0) begin
      $display("** pixel_to_ascii_text: PASSED **");
    end else begin
      $display("** pixel_to_ascii_text: FAILED **");
    end
    $finish;
  end

endmodule
